// ----- design/ata_taskfile_command_sequencer_unit_assert.svh -----
// Assertion macros for the checker file of this block.
// Every macro expects signals named clock and reset in the scope where it is used.
`ifndef ATA_TASKFILE_COMMAND_SEQUENCER_UNIT_ASSERT_SVH
`define ATA_TASKFILE_COMMAND_SEQUENCER_UNIT_ASSERT_SVH

// General property check, disabled while reset is high.
`define ATA_TFS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// A beat that is stalled stays valid and keeps its payload on the next cycle.
`define ATA_TFS_ASSERT_HOLD(lbl, vld, stl, sig) \
   lbl: assert property (@(posedge clock) disable iff (reset) \
      (vld && stl) |=> (vld && $stable(sig))) \
      else $error("stalled beat was dropped or changed");

`endif

// ----- design/ata_tfs_pkg.sv -----
`default_nettype none

package ata_tfs_pkg;

   // Configuration register indexes.
   localparam int CSR_DATA_W = 33;
   localparam logic [1:0] CSR_DEVICE_SECTORS = 2'd0;
   localparam logic [1:0] CSR_LBA_CAPABLE    = 2'd1;
   localparam logic [1:0] CSR_USE_DMA        = 2'd2;
   localparam logic [1:0] CSR_SLAVE_SELECT   = 2'd3;

   // Task-file register selects.
   localparam logic [2:0] REG_FEATURE   = 3'd0;
   localparam logic [2:0] REG_SECT_CNT  = 3'd1;
   localparam logic [2:0] REG_SECTOR    = 3'd2;
   localparam logic [2:0] REG_CYL_LOW   = 3'd3;
   localparam logic [2:0] REG_CYL_HIGH  = 3'd4;
   localparam logic [2:0] REG_DRV_HEAD  = 3'd5;
   localparam logic [2:0] REG_COMMAND   = 3'd6;

   // Command opcodes.
   localparam logic [7:0] CMD_RD_PIO     = 8'h20;
   localparam logic [7:0] CMD_RD_PIO_EXT = 8'h24;
   localparam logic [7:0] CMD_RD_DMA     = 8'hC8;
   localparam logic [7:0] CMD_RD_DMA_EXT = 8'h25;
   localparam logic [7:0] CMD_WR_PIO     = 8'h30;
   localparam logic [7:0] CMD_WR_PIO_EXT = 8'h34;
   localparam logic [7:0] CMD_WR_DMA     = 8'hCA;
   localparam logic [7:0] CMD_WR_DMA_EXT = 8'h35;

   // Drive/head register base values.
   localparam logic [7:0] DH_LBA48 = 8'h40;
   localparam logic [7:0] DH_LBA28 = 8'hE0;
   localparam logic [7:0] DH_CHS   = 8'hA0;

   // CHS geometry: 63 sectors per track, 16 heads.
   localparam int CHS_SECTORS     = 63;
   localparam int CHS_HEADS       = 16;
   localparam int CHS_CYL_SECTORS = CHS_SECTORS * CHS_HEADS;
   // floor(2^38 / 1008); the quotient estimate is exact or one low for 28-bit inputs.
   localparam int CHS_CYL_SHIFT = 38;
   localparam logic [28:0] CHS_CYL_RECIP = 29'd272696336;

   typedef struct packed {
      logic        op;
      logic [31:0] start_lba;
      logic [7:0]  sector_count;
   } req_type;

   typedef struct packed {
      logic [2:0] reg_sel;
      logic [7:0] reg_value;
      logic       out_of_range;
      logic       last_write;
   } rsp_type;

   typedef struct packed {
      logic [32:0] device_sectors;
      logic        lba_capable;
      logic        use_dma;
      logic        slave_select;
   } cfg_type;

   // One decoded request as handed from the front to the back.
   typedef struct packed {
      logic       err;
      logic       need_sel;
      logic       ext;
      logic       ms;
      logic [7:0] count;
      logic [7:0] hob_sector;
      logic [7:0] sector;
      logic [7:0] cyl_lo;
      logic [7:0] cyl_hi;
      logic [7:0] dev_head;
      logic [7:0] command;
   } desc_type;

endpackage

`default_nettype wire

// ----- design/ata_tfs_front.sv -----
`default_nettype none

module ata_tfs_front
   import ata_tfs_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  req_type                      req_data,
   input  cfg_type                      cfg,
   input  logic [$clog2(DEPTH+1)-1:0]   queue_count,
   output logic                         push,
   output desc_type                     push_data
);

   localparam int SUM_W  = $clog2(DEPTH + 4);
   localparam int PROD_W = 57;
   localparam int QUOT_W = PROD_W - CHS_CYL_SHIFT;

   typedef struct packed {
      req_type req;
      logic    err;
      logic    zero;
      logic    need_sel;
      logic    ext;
      logic    chs;
      logic    ms;
      logic    dma;
   } info_type;

   logic                s1_valid_ff;
   req_type             s1_req_ff;
   logic                s2_valid_ff;
   info_type            s2_info_ff;
   logic [QUOT_W-1:0]   s2_quot_ff;
   logic                s3_valid_ff;
   info_type            s3_info_ff;
   logic [15:0]         s3_cyl_ff;
   logic [9:0]          s3_rem_ff;
   logic                sel_valid_ff;
   logic                sel_slave_ff;

   logic [SUM_W-1:0]    in_flight;
   logic                accept;
   logic [32:0]         end_lba;
   info_type            s1_info;
   logic [PROD_W-1:0]   product;
   logic [28:0]         quot_x1008;
   logic [28:0]         rem_full;
   logic [10:0]         rem_est;
   logic                rem_fix;
   logic [QUOT_W-1:0]   quot_fixed;
   logic [9:0]          rem_in;
   logic [15:1]         at_least;
   logic [3:0]          head;
   logic [9:0]          head_x63;
   logic [9:0]          sect;
   logic [7:0]          command;

   // Credit check: everything in the pipe must find room in the queue.
   assign in_flight = SUM_W'(queue_count) + SUM_W'(s1_valid_ff) + SUM_W'(s2_valid_ff)
                      + SUM_W'(s3_valid_ff);
   assign req_stall = (in_flight >= SUM_W'(DEPTH));
   assign accept    = req_valid && !req_stall;

   // Stage 1: range check, drive selection and the cylinder quotient product.
   always_comb begin
      end_lba          = {1'b0, s1_req_ff.start_lba} + 33'(s1_req_ff.sector_count);
      s1_info.req      = s1_req_ff;
      s1_info.err      = (end_lba > cfg.device_sectors);
      s1_info.zero     = (s1_req_ff.sector_count == 8'd0);
      s1_info.need_sel = !sel_valid_ff || (sel_slave_ff != cfg.slave_select);
      s1_info.ext      = (s1_req_ff.start_lba[31:28] != 4'd0);
      s1_info.chs      = !cfg.lba_capable;
      s1_info.ms       = cfg.slave_select;
      s1_info.dma      = cfg.use_dma;
      product          = PROD_W'(s1_req_ff.start_lba[27:0]) * PROD_W'(CHS_CYL_RECIP);
   end

   // Stage 2: the estimate is never high and at most one low, so one correction suffices.
   always_comb begin
      quot_x1008 = {s2_quot_ff, 10'd0} - {6'd0, s2_quot_ff, 4'd0};
      rem_full   = {1'b0, s2_info_ff.req.start_lba[27:0]} - quot_x1008;
      rem_est    = rem_full[10:0];
      rem_fix    = (rem_est >= 11'(CHS_CYL_SECTORS));
      quot_fixed = s2_quot_ff + QUOT_W'(rem_fix);
      rem_in     = rem_fix ? 10'(rem_est - 11'(CHS_CYL_SECTORS)) : rem_est[9:0];
   end

   // Stage 3: head from a thermometer of track boundaries, then the sector.
   always_comb begin
      for (int k = 1; k < CHS_HEADS; k++) begin
         at_least[k] = (s3_rem_ff >= 10'(CHS_SECTORS * k));
      end
      head = 4'd0;
      for (int k = 1; k < CHS_HEADS; k++) begin
         if (at_least[k]) begin
            head = 4'(k);
         end
      end
      head_x63 = {head, 6'd0} - {6'd0, head};
      sect     = s3_rem_ff - head_x63 + 10'd1;
   end

   always_comb begin
      unique case ({s3_info_ff.req.op, s3_info_ff.dma, s3_info_ff.ext})
         3'b000:  command = CMD_RD_PIO;
         3'b001:  command = CMD_RD_PIO_EXT;
         3'b010:  command = CMD_RD_DMA;
         3'b011:  command = CMD_RD_DMA_EXT;
         3'b100:  command = CMD_WR_PIO;
         3'b101:  command = CMD_WR_PIO_EXT;
         3'b110:  command = CMD_WR_DMA;
         3'b111:  command = CMD_WR_DMA_EXT;
         default: command = CMD_RD_PIO;
      endcase
   end

   always_comb begin
      push_data.err        = s3_info_ff.err;
      push_data.need_sel   = s3_info_ff.need_sel;
      push_data.ext        = s3_info_ff.ext;
      push_data.ms         = s3_info_ff.ms;
      push_data.count      = s3_info_ff.req.sector_count;
      push_data.hob_sector = s3_info_ff.req.start_lba[31:24];
      push_data.command    = command;
      if (s3_info_ff.ext) begin
         push_data.sector   = s3_info_ff.req.start_lba[7:0];
         push_data.cyl_lo   = s3_info_ff.req.start_lba[15:8];
         push_data.cyl_hi   = s3_info_ff.req.start_lba[23:16];
         push_data.dev_head = DH_LBA48 | {3'd0, s3_info_ff.ms, 4'd0};
      end else if (!s3_info_ff.chs) begin
         push_data.sector   = s3_info_ff.req.start_lba[7:0];
         push_data.cyl_lo   = s3_info_ff.req.start_lba[15:8];
         push_data.cyl_hi   = s3_info_ff.req.start_lba[23:16];
         push_data.dev_head = DH_LBA28 | {3'd0, s3_info_ff.ms,
                                          s3_info_ff.req.start_lba[27:24]};
      end else begin
         push_data.sector   = sect[7:0];
         push_data.cyl_lo   = s3_cyl_ff[7:0];
         push_data.cyl_hi   = s3_cyl_ff[15:8];
         push_data.dev_head = DH_CHS | {3'd0, s3_info_ff.ms, head};
      end
   end

   assign push = s3_valid_ff && !s3_info_ff.zero;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         sel_valid_ff <= 1'b0;
         sel_slave_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         // Only a request that will reach the drive changes the recorded selection.
         if (s1_valid_ff && !s1_info.zero && !s1_info.err) begin
            sel_valid_ff <= 1'b1;
            sel_slave_ff <= cfg.slave_select;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff <= req_data;
      end
      s2_info_ff <= s1_info;
      s2_quot_ff <= product[PROD_W-1:CHS_CYL_SHIFT];
      s3_info_ff <= s2_info_ff;
      s3_cyl_ff  <= quot_fixed[15:0];
      s3_rem_ff  <= rem_in;
   end

endmodule

`default_nettype wire

// ----- design/ata_tfs_queue.sv -----
`default_nettype none

module ata_tfs_queue
   import ata_tfs_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  desc_type                     push_data,
   input  logic                         pop,
   output logic                         head_valid,
   output desc_type                     head_desc,
   output logic [$clog2(DEPTH+1)-1:0]   count
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   desc_type          entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              do_pop;

   assign head_valid = (count_ff != CNT_W'(0));
   assign head_desc  = entry_ff[rd_ptr_ff];
   assign count      = count_ff;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- design/ata_tfs_back.sv -----
`default_nettype none

module ata_tfs_back
   import ata_tfs_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     head_valid,
   input  desc_type head_desc,
   output logic     pop,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   typedef enum logic [13:0] {
      ST_START     = 14'b00000000000001,
      ST_ERR       = 14'b00000000000010,
      ST_SEL       = 14'b00000000000100,
      ST_HOB_CNT   = 14'b00000000001000,
      ST_HOB_SECT  = 14'b00000000010000,
      ST_HOB_CYLLO = 14'b00000000100000,
      ST_HOB_CYLHI = 14'b00000001000000,
      ST_FEAT      = 14'b00000010000000,
      ST_CNT       = 14'b00000100000000,
      ST_SECT      = 14'b00001000000000,
      ST_CYLLO     = 14'b00010000000000,
      ST_CYLHI     = 14'b00100000000000,
      ST_DH        = 14'b01000000000000,
      ST_CMD       = 14'b10000000000000
   } step_type;

   step_type step_ff;
   step_type step_in;
   step_type first_step;
   step_type cur_step;
   step_type nxt_step;
   rsp_type  beat;
   rsp_type  rsp_data_ff;
   logic     rsp_valid_ff;
   logic     advance;

   assign advance = head_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      priority if (head_desc.err) begin
         first_step = ST_ERR;
      end else if (head_desc.need_sel) begin
         first_step = ST_SEL;
      end else if (head_desc.ext) begin
         first_step = ST_HOB_CNT;
      end else begin
         first_step = ST_FEAT;
      end
      cur_step = (step_ff == ST_START) ? first_step : step_ff;
   end

   always_comb begin
      beat.reg_sel      = REG_FEATURE;
      beat.reg_value    = 8'd0;
      beat.out_of_range = 1'b0;
      beat.last_write   = 1'b0;
      nxt_step          = ST_START;
      unique case (cur_step)
         ST_ERR: begin
            beat.out_of_range = 1'b1;
            beat.last_write   = 1'b1;
         end
         ST_SEL: begin
            beat.reg_sel   = REG_DRV_HEAD;
            beat.reg_value = {3'd0, head_desc.ms, 4'd0};
            nxt_step       = head_desc.ext ? ST_HOB_CNT : ST_FEAT;
         end
         ST_HOB_CNT: begin
            beat.reg_sel = REG_SECT_CNT;
            nxt_step     = ST_HOB_SECT;
         end
         ST_HOB_SECT: begin
            beat.reg_sel   = REG_SECTOR;
            beat.reg_value = head_desc.hob_sector;
            nxt_step       = ST_HOB_CYLLO;
         end
         ST_HOB_CYLLO: begin
            beat.reg_sel = REG_CYL_LOW;
            nxt_step     = ST_HOB_CYLHI;
         end
         ST_HOB_CYLHI: begin
            beat.reg_sel = REG_CYL_HIGH;
            nxt_step     = ST_CNT;
         end
         ST_FEAT: begin
            nxt_step = ST_CNT;
         end
         ST_CNT: begin
            beat.reg_sel   = REG_SECT_CNT;
            beat.reg_value = head_desc.count;
            nxt_step       = ST_SECT;
         end
         ST_SECT: begin
            beat.reg_sel   = REG_SECTOR;
            beat.reg_value = head_desc.sector;
            nxt_step       = ST_CYLLO;
         end
         ST_CYLLO: begin
            beat.reg_sel   = REG_CYL_LOW;
            beat.reg_value = head_desc.cyl_lo;
            nxt_step       = ST_CYLHI;
         end
         ST_CYLHI: begin
            beat.reg_sel   = REG_CYL_HIGH;
            beat.reg_value = head_desc.cyl_hi;
            nxt_step       = ST_DH;
         end
         ST_DH: begin
            beat.reg_sel   = REG_DRV_HEAD;
            beat.reg_value = head_desc.dev_head;
            nxt_step       = ST_CMD;
         end
         ST_CMD: begin
            beat.reg_sel    = REG_COMMAND;
            beat.reg_value  = head_desc.command;
            beat.last_write = 1'b1;
         end
         default: begin
            nxt_step = ST_START;
         end
      endcase
   end

   always_comb begin
      step_in = step_ff;
      if (advance) begin
         step_in = beat.last_write ? ST_START : nxt_step;
      end
   end

   assign pop       = advance && beat.last_write;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= ST_START;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= beat;
      end
   end

endmodule

`default_nettype wire

// ----- design/ata_taskfile_command_sequencer_unit.sv -----
// A request's first write reaches rsp via the front stages, the queue and the output register.
// One register write per cycle unless rsp_stall holds it; a request of n writes (1 to 11)
// holds the back end until its last write; requests queue at one per cycle unless req_stall.
// Reset is synchronous and active high: it restores the configuration registers to their
// defaults, forgets the drive selection and empties the pipeline and the queue.
`default_nettype none

module ata_taskfile_command_sequencer_unit
   import ata_tfs_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_wr_en,
   input  logic [1:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cfg_type           cfg_ff;
   cfg_type           cfg_in;
   logic              push;
   desc_type          push_data;
   logic              pop;
   logic              head_valid;
   desc_type          head_desc;
   logic [CNT_W-1:0]  queue_count;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DEVICE_SECTORS: cfg_in.device_sectors = csr_wdata;
            CSR_LBA_CAPABLE:    cfg_in.lba_capable    = csr_wdata[0];
            CSR_USE_DMA:        cfg_in.use_dma        = csr_wdata[0];
            CSR_SLAVE_SELECT:   cfg_in.slave_select   = csr_wdata[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_sectors <= '0;
         cfg_ff.lba_capable    <= 1'b1;
         cfg_ff.use_dma        <= 1'b0;
         cfg_ff.slave_select   <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ata_tfs_front #(
      .DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .cfg         (cfg_ff),
      .queue_count (queue_count),
      .push        (push),
      .push_data   (push_data)
   );

   ata_tfs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .pop        (pop),
      .head_valid (head_valid),
      .head_desc  (head_desc),
      .count      (queue_count)
   );

   ata_tfs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_desc  (head_desc),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

// ----- design/ata_tfs_checker.sv -----
`default_nettype none
`include "ata_taskfile_command_sequencer_unit_assert.svh"

module ata_tfs_checker
   import ata_tfs_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   `ATA_TFS_ASSERT_HOLD(a_rsp_hold, rsp_valid, rsp_stall, rsp_data)

   // An error beat stands alone and carries no register write.
   `ATA_TFS_ASSERT(a_err_alone, (rsp_valid && rsp_data.out_of_range) |-> (rsp_data.last_write && rsp_data.reg_sel == REG_FEATURE && rsp_data.reg_value == 8'd0), "error beat malformed")

   // A normal request always ends on the command register, and only there.
   `ATA_TFS_ASSERT(a_cmd_last, (rsp_valid && !rsp_data.out_of_range) |-> (rsp_data.last_write == (rsp_data.reg_sel == REG_COMMAND)), "command and last beat disagree")

   `ATA_TFS_ASSERT(a_cmd_opcode, (rsp_valid && rsp_data.reg_sel == REG_COMMAND) |-> (rsp_data.reg_value == CMD_RD_PIO || rsp_data.reg_value == CMD_RD_PIO_EXT || rsp_data.reg_value == CMD_RD_DMA || rsp_data.reg_value == CMD_RD_DMA_EXT || rsp_data.reg_value == CMD_WR_PIO || rsp_data.reg_value == CMD_WR_PIO_EXT || rsp_data.reg_value == CMD_WR_DMA || rsp_data.reg_value == CMD_WR_DMA_EXT), "unknown command opcode")

endmodule

bind ata_taskfile_command_sequencer_unit ata_tfs_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ----- verif/tb.sv -----
`default_nettype none

module tb;
   import ata_tfs_pkg::*;

   // Predicts the task-file register writes of each accepted request and
   // checks the writes that come out of the block against them, in order.
   class taskfile_predictor;
      cfg_type     cfg;
      logic        sel_slave;
      logic        sel_known;
      rsp_type     pending_writes[$];
      int unsigned errors;

      function new();
         cfg = '0;
         cfg.lba_capable = 1'b1;
         sel_slave = 1'b0;
         sel_known = 1'b0;
         errors = 0;
      endfunction

      function void set_config(input cfg_type c);
         cfg = c;
      endfunction

      function int unsigned pending();
         return pending_writes.size();
      endfunction

      function void push_write(input logic [2:0] sel, input logic [7:0] val,
                               input logic last);
         rsp_type w;
         w.reg_sel = sel;
         w.reg_value = val;
         w.out_of_range = 1'b0;
         w.last_write = last;
         pending_writes.push_back(w);
      endfunction

      function void note_request(input req_type r);
         logic        ms;
         logic        ext;
         logic [7:0]  cmd;
         int unsigned sect;
         int unsigned base;
         int unsigned cyl;
         int unsigned head;
         rsp_type     w;
         if (r.sector_count == 8'd0) return;
         if ({1'b0, r.start_lba} + {25'b0, r.sector_count} > cfg.device_sectors) begin
            w = '0;
            w.out_of_range = 1'b1;
            w.last_write = 1'b1;
            pending_writes.push_back(w);
            return;
         end
         ms = cfg.slave_select;
         // The drive-select write only goes out when the selection changes.
         if (!sel_known || sel_slave != ms) begin
            sel_known = 1'b1;
            sel_slave = ms;
            push_write(REG_DRV_HEAD, {3'b000, ms, 4'b0000}, 1'b0);
         end
         ext = r.start_lba >= 32'h1000_0000;
         if (ext) begin
            push_write(REG_SECT_CNT, 8'h00, 1'b0);
            push_write(REG_SECTOR, r.start_lba[31:24], 1'b0);
            push_write(REG_CYL_LOW, 8'h00, 1'b0);
            push_write(REG_CYL_HIGH, 8'h00, 1'b0);
            push_write(REG_SECT_CNT, r.sector_count, 1'b0);
            push_write(REG_SECTOR, r.start_lba[7:0], 1'b0);
            push_write(REG_CYL_LOW, r.start_lba[15:8], 1'b0);
            push_write(REG_CYL_HIGH, r.start_lba[23:16], 1'b0);
            push_write(REG_DRV_HEAD, DH_LBA48 | {3'b000, ms, 4'b0000}, 1'b0);
         end else if (cfg.lba_capable) begin
            push_write(REG_FEATURE, 8'h00, 1'b0);
            push_write(REG_SECT_CNT, r.sector_count, 1'b0);
            push_write(REG_SECTOR, r.start_lba[7:0], 1'b0);
            push_write(REG_CYL_LOW, r.start_lba[15:8], 1'b0);
            push_write(REG_CYL_HIGH, r.start_lba[23:16], 1'b0);
            push_write(REG_DRV_HEAD, DH_LBA28 | {3'b000, ms, r.start_lba[27:24]}, 1'b0);
         end else begin
            sect = r.start_lba % CHS_SECTORS + 1;
            base = r.start_lba + 1 - sect;
            cyl = base / CHS_CYL_SECTORS;
            head = (base % CHS_CYL_SECTORS) / CHS_SECTORS;
            push_write(REG_FEATURE, 8'h00, 1'b0);
            push_write(REG_SECT_CNT, r.sector_count, 1'b0);
            push_write(REG_SECTOR, sect[7:0], 1'b0);
            push_write(REG_CYL_LOW, cyl[7:0], 1'b0);
            push_write(REG_CYL_HIGH, cyl[15:8], 1'b0);
            push_write(REG_DRV_HEAD, DH_CHS | {3'b000, ms, head[3:0]}, 1'b0);
         end
         if (r.op == 1'b0) begin
            if (cfg.use_dma) cmd = ext ? CMD_RD_DMA_EXT : CMD_RD_DMA;
            else cmd = ext ? CMD_RD_PIO_EXT : CMD_RD_PIO;
         end else begin
            if (cfg.use_dma) cmd = ext ? CMD_WR_DMA_EXT : CMD_WR_DMA;
            else cmd = ext ? CMD_WR_PIO_EXT : CMD_WR_PIO;
         end
         push_write(REG_COMMAND, cmd, 1'b1);
      endfunction

      function void check_write(input rsp_type got);
         rsp_type want;
         if (pending_writes.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected write: sel=%0d val=%h oor=%b last=%b",
                        got.reg_sel, got.reg_value, got.out_of_range, got.last_write);
            return;
         end
         want = pending_writes.pop_front();
         if (got.reg_sel !== want.reg_sel || got.reg_value !== want.reg_value ||
             got.out_of_range !== want.out_of_range ||
             got.last_write !== want.last_write) begin
            errors++;
            if (errors <= 10)
               $display({"mismatch: expected sel=%0d val=%h oor=%b last=%b, ",
                         "got sel=%0d val=%h oor=%b last=%b"},
                        want.reg_sel, want.reg_value, want.out_of_range, want.last_write,
                        got.reg_sel, got.reg_value, got.out_of_range, got.last_write);
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_wr_en = 1'b0;
   logic [1:0]            csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   taskfile_predictor tf_pred = new();
   bit                calm = 1'b0;
   int unsigned       stall_left = 0;

   ata_taskfile_command_sequencer_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 5) return 0;
      if (r < 9) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (calm || $urandom_range(0, 2) != 0) begin
         rsp_stall <= 1'b0;
         stall_left <= $urandom_range(0, 6);
      end else begin
         rsp_stall <= 1'b1;
         stall_left <= pick_gap();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) tf_pred.check_write(rsp_data);
   end

   task automatic send_request(input logic op, input logic [31:0] lba, input logic [7:0] cnt);
      req_type     r;
      int unsigned gap;
      r.op = op;
      r.start_lba = lba;
      r.sector_count = cnt;
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      tf_pred.note_request(r);
      gap = calm ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_for_writes(input int unsigned tail);
      req_valid <= 1'b0;
      while (tf_pred.pending() != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // A zero-count request leaves nothing to wait for, so the tail covers a
   // request that may still be in the pipeline.
   task automatic configure(input logic [32:0] ds, input logic cap, input logic dma,
                            input logic slave);
      cfg_type c;
      c.device_sectors = ds;
      c.lba_capable = cap;
      c.use_dma = dma;
      c.slave_select = slave;
      wait_for_writes(12);
      write_csr(CSR_DEVICE_SECTORS, ds);
      write_csr(CSR_LBA_CAPABLE, {32'b0, cap});
      write_csr(CSR_USE_DMA, {32'b0, dma});
      write_csr(CSR_SLAVE_SELECT, {32'b0, slave});
      csr_wr_en <= 1'b0;
      tf_pred.set_config(c);
   endtask

   function automatic logic [31:0] random_lba(input logic [32:0] ds, input logic [7:0] cnt);
      int unsigned mode;
      logic [32:0] near;
      mode = $urandom_range(0, 99);
      if (mode < 35) return $urandom & 32'h0FFF_FFFF;
      if (mode < 60) return $urandom_range(32'hFFFF_FFFF, 32'h1000_0000);
      if (mode < 80 && ds > 33'd1) return $urandom_range(0, 32'(ds - 33'd1));
      if (mode < 90) begin
         near = ds - {25'b0, cnt} + 33'($urandom_range(0, 2)) - 33'd1;
         if (near > 33'h0_FFFF_FFFF) return $urandom;
         return near[31:0];
      end
      return $urandom;
   endfunction

   initial begin
      logic [32:0] ds;
      logic [7:0]  cnt;
      int unsigned r;
      int unsigned hold_at;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset defaults: zero capacity, so every nonzero request is out of range.
      send_request(1'b0, 32'h0000_0000, 8'd0);
      send_request(1'b0, 32'h0000_0000, 8'd1);
      send_request(1'b1, 32'hFFFF_FFFF, 8'd255);

      // Full capacity, LBA addressing, PIO, master.
      configure(33'h1_0000_0000, 1'b1, 1'b0, 1'b0);
      send_request(1'b0, 32'h0000_0000, 8'd1);
      send_request(1'b1, 32'h0FFF_FFFF, 8'd255);
      send_request(1'b0, 32'h1000_0000, 8'd1);
      send_request(1'b1, 32'hFFFF_FFFF, 8'd1);
      send_request(1'b0, 32'hFFFF_FFFF, 8'd2);
      send_request(1'b0, 32'h0000_0005, 8'd0);

      // CHS geometry, DMA, slave drive.
      configure(33'h1_0000_0000, 1'b0, 1'b1, 1'b1);
      send_request(1'b0, 32'h0000_0000, 8'd1);
      send_request(1'b1, 32'd1007, 8'd3);
      send_request(1'b0, 32'd1008, 8'd7);
      send_request(1'b1, 32'h0FFF_FFFF, 8'd255);
      send_request(1'b0, 32'h1000_0000, 8'd1);
      send_request(1'b1, 32'hFFFF_FFFE, 8'd1);

      // Small device back on the master: the out-of-range request must not
      // consume the pending drive-select write.
      configure(33'd100, 1'b1, 1'b0, 1'b0);
      send_request(1'b0, 32'd50, 8'd51);
      send_request(1'b0, 32'd99, 8'd1);
      send_request(1'b1, 32'd0, 8'd100);

      for (int ph = 0; ph < 7; ph++) begin
         r = $urandom_range(0, 3);
         if (r < 2) ds = 33'h1_0000_0000;
         else if (r == 2) ds = {1'b0, 32'($urandom)};
         else ds = 33'($urandom_range(1, 1 << 20));
         configure(ds, ph[0], ph[1], 1'($urandom_range(0, 1)));
         calm = (ph == 2 || ph == 5);
         hold_at = $urandom_range(5, 25);
         for (int i = 0; i < 32; i++) begin
            if (i == hold_at) wait_for_writes(1);
            r = $urandom_range(0, 9);
            if (r == 0) cnt = 8'd0;
            else if (r == 1) cnt = 8'd255;
            else cnt = 8'($urandom_range(1, 255));
            send_request(1'($urandom_range(0, 1)), random_lba(ds, cnt), cnt);
         end
      end
      calm = 1'b0;

      wait_for_writes(20);
      if (tf_pred.errors == 0 && tf_pred.pending() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

`default_nettype wire
